// ===== rtl/bbrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrf_pkg
// Shared types and constants for the burst byte ring FIFO: transaction
// payloads, operation and status codes, and the lane-to-merge control word.
// ----------------------------------------------------------------------------
package bbrf_pkg;

  // Default configuration handed to the top level.
  localparam int DEPTH_DEF     = 256;
  localparam int MAX_BURST_DEF = 8;

  // Eight byte lanes, one per interleaved store bank.
  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  // Operation codes.
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;
  localparam logic [1:0] ACT_DROP = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BURST = 2'd2;

  // Command transaction.
  typedef struct packed {
    logic [1:0]  action;
    logic [8:0]  length;
    logic [63:0] push_data;
  } cmd_t;

  // Result transaction.
  typedef struct packed {
    logic [8:0]  done_count;
    logic [1:0]  status;
    logic [63:0] read_data;
    logic [8:0]  used_bytes;
    logic [8:0]  free_bytes;
  } res_t;

  // Everything the merge stage needs about the item whose bank reads are in flight.
  typedef struct packed {
    logic [8:0]        done_count;
    logic [1:0]        status;
    logic [8:0]        used_bytes;
    logic [8:0]        free_bytes;
    logic              is_read;
    logic [LANE_W-1:0] rot;
    logic [3:0]        nbytes;
  } merge_ctl_t;

endpackage

// ===== rtl/bbrf_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrf_bank
// One interleaved byte bank of the ring store: one write port and one
// registered read port with a read enable.
// ----------------------------------------------------------------------------
module bbrf_bank #(
  parameter int ROWS  = 32,
  parameter int ROW_W = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ROW_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [ROW_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [ROWS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bbrf_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrf_merge
// Merge stage: rotates the eight bank outputs back into stream order,
// zeroes the bytes beyond the burst and builds the result transaction.
// ----------------------------------------------------------------------------
module bbrf_merge (
  input  logic [7:0]          bank_q [bbrf_pkg::LANES],
  input  bbrf_pkg::merge_ctl_t ctl,
  output bbrf_pkg::res_t      res
);

  logic [63:0] rdata;

  // Byte i of the burst sits in the bank that follows the read pointer by i.
  always_comb begin
    logic [bbrf_pkg::LANE_W-1:0] sel;
    rdata = '0;
    for (int i = 0; i < bbrf_pkg::LANES; i++) begin
      sel = ctl.rot + bbrf_pkg::LANE_W'(i);
      if (ctl.is_read && (4'(i) < ctl.nbytes)) begin
        rdata[8*i +: 8] = bank_q[sel];
      end
    end
  end

  // Result transaction.
  always_comb begin
    res.done_count = ctl.done_count;
    res.status     = ctl.status;
    res.read_data  = rdata;
    res.used_bytes = ctl.used_bytes;
    res.free_bytes = ctl.free_bytes;
  end

endmodule

// ===== rtl/burst_byte_ring_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_byte_ring_fifo
// Byte FIFO on a power-of-two ring store split into eight byte banks, with
// all-or-nothing push, pop, peek (bursts up to eight bytes) and drop (any length).
// ----------------------------------------------------------------------------
// A result passes through the bank read register, then the result register.
// Throughput: one command per cycle while the result side is not stalled; all
// eight banks are read at once, and the banks a push covers are written at once.
// Reset: rst clears the pointers, the byte count and both valid flags.
//   The store itself is not cleared; only bytes that were written are read.
module burst_byte_ring_fifo #(
  parameter int DEPTH     = bbrf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = bbrf_pkg::MAX_BURST_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bbrf_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output bbrf_pkg::res_t res
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam int SUM_W = ((CNT_W > 9) ? CNT_W : 9) + 1;
  localparam int ROWS  = DEPTH / bbrf_pkg::LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] held_count;

  logic                 cmd_fire;
  logic                 over_burst;
  logic                 short;
  logic                 ok;
  logic                 is_push;
  logic [SUM_W-1:0]     held_ext;
  logic [SUM_W-1:0]     len_ext;
  logic [SUM_W-1:0]     held_next;
  logic [SUM_W-1:0]     free_ext;
  logic [SUM_W-1:0]     wp_sum;
  logic [SUM_W-1:0]     rp_sum;
  bbrf_pkg::merge_ctl_t ctl_next;
  bbrf_pkg::merge_ctl_t ctl;
  logic                 s1_valid;
  logic                 load;
  bbrf_pkg::res_t       res_next;
  logic [7:0]           bank_q [bbrf_pkg::LANES];

  // Handshake: the bank stage advances whenever the result register can take it.
  assign load      = s1_valid && (!res_valid || res_ready);
  assign cmd_ready = !s1_valid || load;
  assign cmd_fire  = cmd_valid && cmd_ready;

  // Decide the operation and the byte count it leaves behind.
  always_comb begin
    held_ext   = SUM_W'(held_count);
    len_ext    = SUM_W'(cmd.length);
    is_push    = (cmd.action == bbrf_pkg::ACT_PUSH);
    over_burst = (cmd.action != bbrf_pkg::ACT_DROP) && (cmd.length > 9'(MAX_BURST));
    if (is_push) begin
      short = (held_ext + len_ext) > SUM_W'(DEPTH);
    end else begin
      short = len_ext > held_ext;
    end
    ok = !over_burst && !short;
    held_next = held_ext;
    if (ok) begin
      if (is_push) begin
        held_next = held_ext + len_ext;
      end else if (cmd.action != bbrf_pkg::ACT_PEEK) begin
        held_next = held_ext - len_ext;
      end
    end
    free_ext = SUM_W'(DEPTH) - held_next;
    wp_sum   = SUM_W'(wp) + len_ext;
    rp_sum   = SUM_W'(rp) + len_ext;
  end

  // Control word for the merge stage.
  always_comb begin
    ctl_next.done_count = ok ? cmd.length : 9'd0;
    ctl_next.status     = over_burst ? bbrf_pkg::ST_BURST :
                          (short ? bbrf_pkg::ST_SHORT : bbrf_pkg::ST_OK);
    ctl_next.used_bytes = held_next[8:0];
    ctl_next.free_bytes = free_ext[8:0];
    ctl_next.is_read    = ok && ((cmd.action == bbrf_pkg::ACT_POP) ||
                                 (cmd.action == bbrf_pkg::ACT_PEEK));
    ctl_next.rot        = rp[bbrf_pkg::LANE_W-1:0];
    ctl_next.nbytes     = cmd.length[3:0];
  end

  // Pointers and byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      held_count <= '0;
    end else if (cmd_fire) begin
      held_count <= held_next[CNT_W-1:0];
      if (ok && is_push) begin
        wp <= wp_sum[PTR_W-1:0];
      end
      if (ok && ((cmd.action == bbrf_pkg::ACT_POP) ||
                 (cmd.action == bbrf_pkg::ACT_DROP))) begin
        rp <= rp_sum[PTR_W-1:0];
      end
    end
  end

  // Byte lanes: each bank takes the burst byte that lands on it.
  for (genvar b = 0; b < bbrf_pkg::LANES; b++) begin : g_lane
    logic [bbrf_pkg::LANE_W-1:0] woff;
    logic [bbrf_pkg::LANE_W-1:0] roff;
    logic [PTR_W-1:0]            waddr;
    logic [PTR_W-1:0]            raddr;
    logic                        we;

    assign woff  = bbrf_pkg::LANE_W'(b) - wp[bbrf_pkg::LANE_W-1:0];
    assign roff  = bbrf_pkg::LANE_W'(b) - rp[bbrf_pkg::LANE_W-1:0];
    assign waddr = wp + PTR_W'(woff);
    assign raddr = rp + PTR_W'(roff);
    assign we    = cmd_fire && ok && is_push && ({1'b0, woff} < cmd.length[3:0]);

    bbrf_bank #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk   (clk),
      .we    (we),
      .waddr (ROW_W'(waddr >> bbrf_pkg::LANE_W)),
      .wdata (cmd.push_data[8*woff +: 8]),
      .re    (cmd_fire),
      .raddr (ROW_W'(raddr >> bbrf_pkg::LANE_W)),
      .rdata (bank_q[b])
    );
  end

  // Bank stage control, held while the result register is blocked.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_fire) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      ctl <= ctl_next;
    end
  end

  // Merge the lanes into the result transaction.
  bbrf_merge u_merge (
    .bank_q (bank_q),
    .ctl    (ctl),
    .res    (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  // The byte count never exceeds the ring size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(DEPTH))
    else $error("byte count above depth");

  // The pointer distance always matches the byte count.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wp - rp) == held_count[PTR_W-1:0])
    else $error("pointers disagree with byte count");

  // A refused transaction moves nothing and returns no data.
  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.status != bbrf_pkg::ST_OK)) |->
    ((res.done_count == 9'd0) && (res.read_data == 64'd0)))
    else $error("refused transaction carries data");

  // A pending bank read is not lost while the result is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res_valid && !res_ready) |=> s1_valid)
    else $error("bank stage dropped while stalled");
`endif

endmodule
